FILE: rtl/core/lpht_pkg.sv
// Shared types and constants for the linear-probe hash table.
// Holds field widths, operation and status codes, and the controller/datapath structs.
// No dependencies.
package lpht_pkg;

    localparam int KEY_W    = 32;
    localparam int HASH_W   = 32;
    localparam int VAL_W    = 32;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int LIMIT_W  = 8;
    localparam int USED_W   = 9;

    localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RST = 8'd192;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_GET = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SET = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEL = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RSV = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STS_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL = 2'd2;

    typedef struct packed {
        logic clear_step;
        logic load_req;
        logic probe_start;
        logic probe_step;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic hash_done;
        logic req_trivial;
        logic probe_done;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/core/lpht_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lpht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/lpht_mod.sv
// Reduces the 32-bit key hash to a home slot index, hash mod CAPACITY.
// A mask for power-of-two sizes, otherwise a registered reciprocal multiply.
// Depends on lpht_pkg.
module lpht_mod #(
    parameter int CAPACITY = 256
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [lpht_pkg::HASH_W-1:0] hash,
    output logic                        done,
    output logic [$clog2(CAPACITY)-1:0] idx
);
    import lpht_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam bit IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
    localparam logic [IDX_W-1:0] CAP_V = IDX_W'(CAPACITY);
    // 2^32 + RECIP_LO = ceil(2^(32+IDX_W) / CAPACITY); exact quotient for every 32-bit hash
    localparam logic [63:0] RECIP =
        ((64'd1 << (HASH_W + IDX_W)) + 64'(CAPACITY) - 64'd1) / 64'(CAPACITY);
    localparam logic [HASH_W-1:0] RECIP_LO = RECIP[HASH_W-1:0];
    localparam int Q_SHIFT = HASH_W + IDX_W;

    logic                hash_vld_reg;
    logic                prod_vld_reg;
    logic                quot_vld_reg;
    logic                done_reg;
    logic [HASH_W-1:0]   hash_reg;
    logic [2*HASH_W-1:0] prod_reg;
    logic [IDX_W-1:0]    quot_reg;
    logic [IDX_W-1:0]    rem_reg;
    logic [2*HASH_W:0]   recip_sum;

    assign recip_sum = {1'b0, hash_reg, {HASH_W{1'b0}}} + {1'b0, prod_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_vld_reg <= 1'b0;
            prod_vld_reg <= 1'b0;
            quot_vld_reg <= 1'b0;
            done_reg     <= 1'b0;
        end else if (start) begin
            hash_vld_reg <= !IS_POW2;
            prod_vld_reg <= 1'b0;
            quot_vld_reg <= 1'b0;
            done_reg     <= IS_POW2;
        end else begin
            hash_vld_reg <= 1'b0;
            prod_vld_reg <= hash_vld_reg;
            quot_vld_reg <= prod_vld_reg;
            done_reg     <= quot_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            hash_reg <= hash;
            if (IS_POW2) begin
                rem_reg <= hash[IDX_W-1:0];
            end
        end
        if (hash_vld_reg) begin
            prod_reg <= (2*HASH_W)'(hash_reg) * (2*HASH_W)'(RECIP_LO);
        end
        if (prod_vld_reg) begin
            quot_reg <= recip_sum[Q_SHIFT +: IDX_W];
        end
        // remainder is below CAPACITY, so the low index bits carry it
        if (quot_vld_reg) begin
            rem_reg <= hash_reg[IDX_W-1:0] - quot_reg * CAP_V;
        end
    end

    assign done = done_reg;
    assign idx  = rem_reg;

endmodule

FILE: rtl/core/lpht_datapath.sv
// Datapath of the hash table: request latch, slot stores, probe tracking, commit and
// output register. Driven by lpht_ctrl through dp_cmd_t, reports through dp_status_t.
// Depends on lpht_pkg, lpht_ram, lpht_mod.
module lpht_datapath #(
    parameter int CAPACITY = 256
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  lpht_pkg::dp_cmd_t                         dp_cmd,
    output lpht_pkg::dp_status_t                      dp_status,
    input  logic [lpht_pkg::MODE_W-1:0]               s_tuser,
    input  logic [lpht_pkg::KEY_W+lpht_pkg::HASH_W+lpht_pkg::VAL_W-1:0] s_tdata,
    input  logic                                      cfg_we,
    input  logic [lpht_pkg::LIMIT_W-1:0]              cfg_wdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [lpht_pkg::STATUS_W:0]               m_tuser,
    output logic [lpht_pkg::VAL_W-1:0]                m_tdata
);
    import lpht_pkg::*;

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int ENTRY_W = KEY_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam int LIM_CAP = (CAPACITY - 1 < 255) ? CAPACITY - 1 : 255;
    localparam logic [LIMIT_W-1:0] LIM_CAP_V = LIMIT_W'(LIM_CAP);

    // request
    logic [MODE_W-1:0] mode_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [VAL_W-1:0]  val_reg;
    logic              trivial_reg;

    // table state
    logic [LIMIT_W-1:0] load_limit_reg;
    logic [USED_W-1:0]  used_reg;
    logic [IDX_W-1:0]   clr_addr_reg;

    // probe tracking
    logic [IDX_W-1:0] issue_addr_reg;
    logic [IDX_W-1:0] chk_addr_reg;
    logic             chk_valid_reg;
    logic [IDX_W-1:0] count_reg;
    logic             hit_found_reg;
    logic             tomb_found_reg;
    logic             empty_found_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [IDX_W-1:0] tomb_idx_reg;
    logic [IDX_W-1:0] empty_idx_reg;
    logic [VAL_W-1:0] hit_val_reg;

    // output
    logic                m_tvalid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_newk_reg;
    logic [VAL_W-1:0]    out_value_reg;

    logic               hash_done;
    logic [IDX_W-1:0]   home_idx;
    logic [ENTRY_W-1:0] key_rdata;
    logic [VAL_W-1:0]   val_rdata;
    logic               key_we;
    logic [IDX_W-1:0]   key_waddr;
    logic [ENTRY_W-1:0] key_wdata;
    logic               val_we;
    logic [IDX_W-1:0]   val_waddr;

    logic               cm_key_we;
    logic [IDX_W-1:0]   cm_key_addr;
    logic [ENTRY_W-1:0] cm_key_data;
    logic               cm_val_we;
    logic [IDX_W-1:0]   cm_val_addr;
    logic               cm_used_inc;
    logic [STATUS_W-1:0] res_status;
    logic               res_newk;
    logic [VAL_W-1:0]   res_value;
    logic [LIMIT_W-1:0] lim_eff;
    logic               room;
    logic [IDX_W-1:0]   target_idx;

    logic [KEY_W-1:0] entry_key;
    logic             entry_tomb;
    logic             is_empty;
    logic             is_tomb;
    logic             is_match;
    logic             out_free;

    lpht_mod #(.CAPACITY(CAPACITY)) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dp_cmd.load_req),
        .hash    (s_tdata[KEY_W+HASH_W-1:KEY_W]),
        .done    (hash_done),
        .idx     (home_idx)
    );

    // entry = {tombstone, key}
    lpht_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_key_ram (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (issue_addr_reg),
        .rdata (key_rdata)
    );

    lpht_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
        .aclk  (aclk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_reg),
        .raddr (issue_addr_reg),
        .rdata (val_rdata)
    );

    // slot classification of the entry read last cycle
    assign entry_key  = key_rdata[KEY_W-1:0];
    assign entry_tomb = key_rdata[KEY_W];
    assign is_empty   = (entry_key == '0) && !entry_tomb;
    assign is_tomb    = (entry_key == '0) && entry_tomb;
    assign is_match   = (entry_key != '0) && (entry_key == key_reg);

    assign out_free = !m_tvalid_reg || m_tready;

    assign lim_eff    = (load_limit_reg > LIM_CAP_V) ? LIM_CAP_V : load_limit_reg;
    assign room       = empty_found_reg && ((used_reg + 1'b1) <= {1'b0, lim_eff});
    assign target_idx = tomb_found_reg ? tomb_idx_reg : empty_idx_reg;

    always_comb begin
        cm_key_we   = 1'b0;
        cm_key_addr = hit_idx_reg;
        cm_key_data = '0;
        cm_val_we   = 1'b0;
        cm_val_addr = hit_idx_reg;
        cm_used_inc = 1'b0;
        res_status  = STS_MISS;
        res_newk    = 1'b0;
        res_value   = '0;
        if (!trivial_reg) begin
            case (mode_reg)
                MODE_GET: begin
                    if (hit_found_reg) begin
                        res_status = STS_OK;
                        res_value  = hit_val_reg;
                    end
                end
                MODE_DEL: begin
                    if (hit_found_reg) begin
                        cm_key_we   = 1'b1;
                        cm_key_data = {1'b1, {KEY_W{1'b0}}};
                        res_status  = STS_OK;
                    end
                end
                MODE_SET: begin
                    if (hit_found_reg) begin
                        cm_val_we  = 1'b1;
                        res_status = STS_OK;
                    end else if (tomb_found_reg || room) begin
                        // a reused tombstone does not grow the used count
                        cm_key_we   = 1'b1;
                        cm_key_addr = target_idx;
                        cm_key_data = {1'b0, key_reg};
                        cm_val_we   = 1'b1;
                        cm_val_addr = target_idx;
                        cm_used_inc = !tomb_found_reg;
                        res_status  = STS_OK;
                        res_newk    = 1'b1;
                    end else begin
                        res_status = STS_FULL;
                    end
                end
                default: ;
            endcase
        end
    end

    // the clearing sweep writes empty entries
    assign key_we    = dp_cmd.clear_step || (dp_cmd.commit && cm_key_we);
    assign key_waddr = dp_cmd.clear_step ? clr_addr_reg : cm_key_addr;
    assign key_wdata = dp_cmd.clear_step ? '0 : cm_key_data;
    assign val_we    = dp_cmd.commit && cm_val_we;
    assign val_waddr = cm_val_addr;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_limit_reg <= LOAD_LIMIT_RST;
            used_reg       <= '0;
            clr_addr_reg   <= '0;
            chk_valid_reg  <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                load_limit_reg <= cfg_wdata;
            end
            if (dp_cmd.clear_step) begin
                clr_addr_reg <= (clr_addr_reg == LAST_IDX) ? '0 : clr_addr_reg + 1'b1;
            end
            if (dp_cmd.commit && cm_used_inc) begin
                used_reg <= used_reg + 1'b1;
            end
            if (dp_cmd.probe_start) begin
                chk_valid_reg <= 1'b0;
            end else if (dp_cmd.probe_step) begin
                chk_valid_reg <= 1'b1;
            end
            if (dp_cmd.commit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (dp_cmd.load_req) begin
            mode_reg    <= s_tuser;
            key_reg     <= s_tdata[KEY_W-1:0];
            val_reg     <= s_tdata[KEY_W+HASH_W+VAL_W-1:KEY_W+HASH_W];
            trivial_reg <= (s_tuser == MODE_RSV) || (s_tdata[KEY_W-1:0] == '0);
        end
        if (dp_cmd.probe_start) begin
            issue_addr_reg  <= home_idx;
            count_reg       <= '0;
            hit_found_reg   <= 1'b0;
            tomb_found_reg  <= 1'b0;
            empty_found_reg <= 1'b0;
        end else if (dp_cmd.probe_step) begin
            issue_addr_reg <= (issue_addr_reg == LAST_IDX) ? '0 : issue_addr_reg + 1'b1;
            chk_addr_reg   <= issue_addr_reg;
            if (chk_valid_reg) begin
                count_reg <= count_reg + 1'b1;
                if (is_tomb && !tomb_found_reg) begin
                    tomb_found_reg <= 1'b1;
                    tomb_idx_reg   <= chk_addr_reg;
                end
                if (is_match) begin
                    hit_found_reg <= 1'b1;
                    hit_idx_reg   <= chk_addr_reg;
                    hit_val_reg   <= val_rdata;
                end
                if (is_empty) begin
                    empty_found_reg <= 1'b1;
                    empty_idx_reg   <= chk_addr_reg;
                end
            end
        end
        if (dp_cmd.commit) begin
            out_status_reg <= res_status;
            out_newk_reg   <= res_newk;
            out_value_reg  <= res_value;
        end
    end

    assign dp_status.clear_done  = (clr_addr_reg == LAST_IDX);
    assign dp_status.hash_done   = hash_done;
    assign dp_status.req_trivial = trivial_reg;
    // stop at an empty slot, a match, or after every slot was visited
    assign dp_status.probe_done  = chk_valid_reg &&
                                   (is_empty || is_match || (count_reg == LAST_IDX));
    assign dp_status.out_free    = out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = {out_newk_reg, out_status_reg};
    assign m_tdata  = out_value_reg;

endmodule

FILE: rtl/core/lpht_ctrl.sv
// Controller of the hash table: clearing sweep, request acceptance, hash wait,
// probe walk and commit sequencing. Depends on lpht_pkg.
module lpht_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  lpht_pkg::dp_status_t dp_status,
    output lpht_pkg::dp_cmd_t    dp_cmd
);
    import lpht_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_HASH   = 5'b00100,
        S_PROBE  = 5'b01000,
        S_COMMIT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        dp_cmd     = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                dp_cmd.clear_step = 1'b1;
                if (dp_status.clear_done) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    dp_cmd.load_req = 1'b1;
                    state_next      = S_HASH;
                end
            end
            S_HASH: begin
                // zero key or reserved mode skips the probe
                if (dp_status.req_trivial) begin
                    state_next = S_COMMIT;
                end else if (dp_status.hash_done) begin
                    dp_cmd.probe_start = 1'b1;
                    state_next         = S_PROBE;
                end
            end
            S_PROBE: begin
                dp_cmd.probe_step = 1'b1;
                if (dp_status.probe_done) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (dp_status.out_free) begin
                    dp_cmd.commit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/linear_probe_hash_table.sv
// Linear-probe hash table, top level.
// Input channel s_*: one request per transfer (get, set or delete), mode on s_tuser,
// key identity, precomputed hash and value on s_tdata. Output channel m_*: one
// result per request, status and new-key flag on m_tuser, found value on m_tdata.
// cfg_we/cfg_wdata write the load limit; write only while no request is in flight.
// After reset the slot store is swept clean, one slot per cycle, with s_tready low;
// the load limit returns to 192 and the used count to zero.
// One request is worked at a time; a new request is taken only once the last one
// has committed its result. Slots are probed one per cycle through the key RAM
// read port; for a CAPACITY that is not a power of two, the hash is first reduced
// by the reciprocal multiply. A waiting result sits in the output register; if
// m_tready is low the next request is still taken and probed, and waits at
// commit until the output register is free.
// Depends on lpht_pkg, lpht_ctrl, lpht_datapath.
module linear_probe_hash_table #(
    parameter int CAPACITY = 256
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [lpht_pkg::MODE_W-1:0]          s_tuser,   // mode
    input  logic [lpht_pkg::KEY_W+lpht_pkg::HASH_W+lpht_pkg::VAL_W-1:0] s_tdata,
                                                            // key_id, key_hash, value_in
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [lpht_pkg::STATUS_W:0]          m_tuser,   // status, new_key
    output logic [lpht_pkg::VAL_W-1:0]           m_tdata,   // value_out
    input  logic                                 cfg_we,
    input  logic [lpht_pkg::LIMIT_W-1:0]         cfg_wdata  // load_limit
);
    import lpht_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    lpht_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    lpht_datapath #(.CAPACITY(CAPACITY)) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .dp_cmd    (dp_cmd),
        .dp_status (dp_status),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

endmodule
